[rtl/slrb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slrb_pkg;

	// longest run that is counted; longer runs saturate here
	localparam int unsigned RUN_LIMIT = 4095;
	localparam int unsigned RUN_W     = $clog2(RUN_LIMIT + 1);

	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned MODE_W    = 3;
	localparam int unsigned COUNT_W   = 11;
	localparam int unsigned COUNT_MAX = 2047;
	localparam int unsigned CAL_CNT_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 16;

	// bit rate / sample rate = 3145728 / 10000000 = 24576 / 78125
	localparam longint unsigned SCALE_NUM = 24576;
	localparam longint unsigned SCALE_DEN = 78125;
	// denominator is odd, so a tie never occurs: round = floor((x + (den-1)/2) / den)
	localparam longint unsigned HALF_DEN  = (SCALE_DEN - 1) / 2;

	// reciprocal divide: floor(x / den) == (x * RECIP) >> RECIP_SH for x < 2**NUM_W
	localparam int unsigned     NUM_W    = RUN_W + 16;
	localparam int unsigned     RECIP_SH = NUM_W + 17;
	localparam int unsigned     RECIP_W  = RECIP_SH - 16;
	localparam longint unsigned RECIP    = ((64'd1 << RECIP_SH) + SCALE_DEN - 1) / SCALE_DEN;
	localparam int unsigned     PROD_W   = NUM_W + RECIP_W;
	localparam int unsigned     Q_W      = RUN_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_DATA    = 3'd0,
		MODE_CAL     = 3'd1,
		MODE_CAL_END = 3'd2,
		MODE_FLUSH   = 3'd3,
		MODE_CLEAR   = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INVERT     = 2'd0,
		CFG_MAN_THRESH = 2'd1,
		CFG_MAN_ENABLE = 2'd2,
		CFG_CAL_LENGTH = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [MODE_W-1:0]          mode;
		logic signed [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic               bit_level;
		logic [COUNT_W-1:0] bit_count;
	} out_item_t;

	// a finished run on its way to the scaler
	typedef struct packed {
		logic             level;
		logic             flush;
		logic [RUN_W-1:0] run;
	} run_end_t;

endpackage

`default_nettype wire

[rtl/slrb_scale.sv]
`timescale 1ns / 1ps
`default_nettype none

module slrb_scale (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   run_valid,
	input  slrb_pkg::run_end_t    run_data,
	output logic                  run_ready,
	output logic                  out_valid,
	output slrb_pkg::out_item_t   out_data,
	input  wire                   out_stall
);

	logic                          valid_s2;
	logic                          level_s2;
	logic                          flush_s2;
	logic [slrb_pkg::Q_W-1:0]      q_s2;

	logic                          out_valid_q;
	slrb_pkg::out_item_t           out_data_q;

	logic                          out_load;
	logic                          s2_free;
	logic [slrb_pkg::NUM_W-1:0]    num;
	logic [slrb_pkg::PROD_W-1:0]   prod;
	logic [slrb_pkg::COUNT_W-1:0]  cnt_sat;
	logic [slrb_pkg::COUNT_W-1:0]  cnt;
	logic                          emit;

	assign out_load  = !out_valid_q || !out_stall;
	assign s2_free   = !valid_s2 || out_load;
	assign run_ready = s2_free;

	// run * 24576 + rounding offset, then divide by 78125 through the reciprocal
	assign num  = slrb_pkg::NUM_W'(run_data.run) * slrb_pkg::NUM_W'(slrb_pkg::SCALE_NUM)
		+ slrb_pkg::NUM_W'(slrb_pkg::HALF_DEN);
	assign prod = slrb_pkg::PROD_W'(num) * slrb_pkg::PROD_W'(slrb_pkg::RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= run_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && run_valid) begin
			level_s2 <= run_data.level;
			flush_s2 <= run_data.flush;
			q_s2     <= prod[slrb_pkg::RECIP_SH +: slrb_pkg::Q_W];
		end
	end

	always_comb begin
		if (32'(q_s2) > 32'(slrb_pkg::COUNT_MAX))
			cnt_sat = slrb_pkg::COUNT_W'(slrb_pkg::COUNT_MAX);
		else
			cnt_sat = slrb_pkg::COUNT_W'(q_s2);
		// a level change always reports at least one bit; a flush of zero bits is dropped
		cnt  = cnt_sat;
		emit = 1'b1;
		if (cnt_sat == '0) begin
			if (flush_s2)
				emit = 1'b0;
			else
				cnt = slrb_pkg::COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s2 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s2) begin
			out_data_q.bit_level <= level_s2;
			out_data_q.bit_count <= cnt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

[rtl/sliced_run_length_bit_recovery.sv]
`timescale 1ns / 1ps
`default_nettype none
// A result reaches out_valid through the run register, the scaling multiply register and
// the output register after the transfer of the item that closes the run.
// Throughput: one item per cycle while in_stall is low; the run and calibration state update
// in the cycle of the transfer, and the count scaling is pipelined behind it.
// Reset (arst_n low, asynchronous): registers, runs and calibration clear, no threshold.

module sliced_run_length_bit_recovery (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  slrb_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  wire                               out_stall,
	output slrb_pkg::out_item_t               out_data,
	input  wire                               cfg_wr_en,
	input  wire [slrb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [slrb_pkg::CFG_W-1:0]         cfg_data
);

	// configuration
	logic                                  invert_q;
	logic signed [slrb_pkg::SAMPLE_W-1:0]  man_thresh_q;
	logic                                  man_enable_q;
	logic [slrb_pkg::CAL_CNT_W-1:0]        cal_length_q;

	// run and calibration state
	logic [slrb_pkg::RUN_W-1:0]            run_len_q;
	logic                                  run_high_q;
	logic signed [slrb_pkg::SAMPLE_W-1:0]  cal_thresh_q;
	logic                                  cal_valid_q;
	logic signed [slrb_pkg::SAMPLE_W-1:0]  cal_min_q;
	logic signed [slrb_pkg::SAMPLE_W-1:0]  cal_max_q;
	logic [slrb_pkg::CAL_CNT_W-1:0]        cal_seen_q;

	logic                                  valid_s1;
	slrb_pkg::run_end_t                    end_s1;

	logic [slrb_pkg::RUN_W-1:0]            run_len_d;
	logic                                  run_high_d;
	logic signed [slrb_pkg::SAMPLE_W-1:0]  cal_thresh_d;
	logic                                  cal_valid_d;
	logic signed [slrb_pkg::SAMPLE_W-1:0]  cal_min_d;
	logic signed [slrb_pkg::SAMPLE_W-1:0]  cal_max_d;
	logic [slrb_pkg::CAL_CNT_W-1:0]        cal_seen_d;
	logic                                  emit_d;
	slrb_pkg::run_end_t                    end_d;

	logic                                  accept;
	logic                                  s1_ready;
	logic                                  thr_valid;
	logic signed [slrb_pkg::SAMPLE_W-1:0]  thr;
	logic                                  high;
	logic signed [slrb_pkg::SAMPLE_W:0]    cal_sum;
	logic signed [slrb_pkg::SAMPLE_W:0]    cal_sum_adj;

	assign in_stall = valid_s1 && !s1_ready;
	assign accept   = in_valid && !in_stall;

	assign thr_valid = man_enable_q || cal_valid_q;
	assign thr       = man_enable_q ? man_thresh_q : cal_thresh_q;
	assign high      = (in_data.sample >= thr);

	// midpoint, truncated toward zero
	assign cal_sum     = {cal_min_q[slrb_pkg::SAMPLE_W-1], cal_min_q}
		+ {cal_max_q[slrb_pkg::SAMPLE_W-1], cal_max_q};
	assign cal_sum_adj = cal_sum + {{slrb_pkg::SAMPLE_W{1'b0}}, cal_sum[slrb_pkg::SAMPLE_W]};

	always_comb begin
		run_len_d    = run_len_q;
		run_high_d   = run_high_q;
		cal_thresh_d = cal_thresh_q;
		cal_valid_d  = cal_valid_q;
		cal_min_d    = cal_min_q;
		cal_max_d    = cal_max_q;
		cal_seen_d   = cal_seen_q;
		emit_d       = 1'b0;
		end_d.level  = ~run_high_q ^ invert_q;
		end_d.flush  = 1'b0;
		end_d.run    = run_len_q;

		case (slrb_pkg::mode_t'(in_data.mode))
			slrb_pkg::MODE_DATA: begin
				if (thr_valid) begin
					if (run_len_q == '0) begin
						run_len_d  = slrb_pkg::RUN_W'(1);
						run_high_d = high;
					end else if (high == run_high_q) begin
						if (run_len_q < slrb_pkg::RUN_W'(slrb_pkg::RUN_LIMIT))
							run_len_d = run_len_q + slrb_pkg::RUN_W'(1);
					end else begin
						emit_d     = 1'b1;
						run_len_d  = slrb_pkg::RUN_W'(1);
						run_high_d = high;
					end
				end
			end
			slrb_pkg::MODE_CAL: begin
				if (!(cal_length_q != '0 && cal_seen_q >= cal_length_q)) begin
					if (cal_seen_q == '0) begin
						cal_min_d = in_data.sample;
						cal_max_d = in_data.sample;
					end else begin
						if (in_data.sample < cal_min_q)
							cal_min_d = in_data.sample;
						if (in_data.sample > cal_max_q)
							cal_max_d = in_data.sample;
					end
					if (cal_seen_q != '1)
						cal_seen_d = cal_seen_q + slrb_pkg::CAL_CNT_W'(1);
				end
			end
			slrb_pkg::MODE_CAL_END: begin
				if (cal_seen_q != '0) begin
					cal_thresh_d = cal_sum_adj[slrb_pkg::SAMPLE_W:1];
					cal_valid_d  = 1'b1;
					cal_seen_d   = '0;
				end
			end
			slrb_pkg::MODE_FLUSH: begin
				if (thr_valid && run_len_q != '0) begin
					emit_d      = 1'b1;
					end_d.flush = 1'b1;
					run_len_d   = '0;
					run_high_d  = 1'b0;
				end
			end
			slrb_pkg::MODE_CLEAR: begin
				run_len_d  = '0;
				run_high_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q     <= 1'b0;
			man_thresh_q <= '0;
			man_enable_q <= 1'b0;
			cal_length_q <= '0;
		end else if (cfg_wr_en) begin
			case (slrb_pkg::cfg_index_t'(cfg_index))
				slrb_pkg::CFG_INVERT:     invert_q     <= cfg_data[0];
				slrb_pkg::CFG_MAN_THRESH: man_thresh_q <= cfg_data;
				slrb_pkg::CFG_MAN_ENABLE: man_enable_q <= cfg_data[0];
				slrb_pkg::CFG_CAL_LENGTH: cal_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q    <= '0;
			run_high_q   <= 1'b0;
			cal_thresh_q <= '0;
			cal_valid_q  <= 1'b0;
			cal_min_q    <= '0;
			cal_max_q    <= '0;
			cal_seen_q   <= '0;
		end else if (accept) begin
			run_len_q    <= run_len_d;
			run_high_q   <= run_high_d;
			cal_thresh_q <= cal_thresh_d;
			cal_valid_q  <= cal_valid_d;
			cal_min_q    <= cal_min_d;
			cal_max_q    <= cal_max_d;
			cal_seen_q   <= cal_seen_d;
		end
	end

	// a transfer is only taken when stage 1 is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit_d;
		end else if (s1_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit_d) begin
			end_s1 <= end_d;
		end
	end

	slrb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_valid (valid_s1),
		.run_data  (end_s1),
		.run_ready (s1_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_stall (out_stall)
	);

endmodule

`default_nettype wire

[tb/sliced_run_length_bit_recovery_test.sv]
`timescale 1ns / 1ps

module sliced_run_length_bit_recovery_test;
	import slrb_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned DRAIN_LIMIT   = 20000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned PHASE_ITEMS   = 85;

	// mode codes the block has no use for
	localparam logic [MODE_W-1:0] MODE_IGNORED_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_IGNORED_LAST  = 3'd7;

	localparam longint unsigned BIT_RATE = 3145728;
	localparam longint unsigned ADC_RATE = 10000000;

	typedef enum {CHECK_MODEL, CHECK_NONE, CHECK_GIVEN} row_check_t;

	typedef struct {
		logic [MODE_W-1:0]          mode;
		logic signed [SAMPLE_W-1:0] sample;
		row_check_t                 check;
		logic                       lvl;
		logic [COUNT_W-1:0]         cnt;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;
	logic                 cfg_wr_en;
	cfg_index_t           cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	sliced_run_length_bit_recovery u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// slicer copy: registers
	bit                         pol_inv;
	logic signed [SAMPLE_W-1:0] man_thr;
	bit                         man_en;
	logic [CAL_CNT_W-1:0]       cal_len;
	// slicer copy: state
	logic [RUN_W-1:0]           run_len;
	bit                         run_high;
	logic signed [SAMPLE_W-1:0] cal_thr;
	bit                         cal_ok;
	logic signed [SAMPLE_W-1:0] cal_lo;
	logic signed [SAMPLE_W-1:0] cal_hi;
	logic [CAL_CNT_W-1:0]       cal_seen;

	out_item_t   awaited_runs [$];
	int unsigned mismatches;
	int unsigned cycle_cnt;
	int unsigned snd_idle_pct;
	int unsigned rcv_stall_pct;
	bit          hold_req;

	row_t plan [0:23] = '{
		'{MODE_DATA,          32767,    CHECK_NONE,  1'b0, 11'd0},
		'{MODE_FLUSH,         0,        CHECK_NONE,  1'b0, 11'd0},
		'{MODE_CAL_END,       0,        CHECK_NONE,  1'b0, 11'd0},
		'{MODE_CAL,           -32768,   CHECK_NONE,  1'b0, 11'd0},
		'{MODE_CAL,           32767,    CHECK_NONE,  1'b0, 11'd0},
		'{MODE_CAL_END,       0,        CHECK_NONE,  1'b0, 11'd0},
		'{MODE_DATA,          0,        CHECK_NONE,  1'b0, 11'd0},
		'{MODE_DATA,          32767,    CHECK_NONE,  1'b0, 11'd0},
		'{MODE_DATA,          -1,       CHECK_GIVEN, 1'b0, 11'd1},
		'{MODE_FLUSH,         0,        CHECK_NONE,  1'b0, 11'd0},
		'{MODE_DATA,          -32768,   CHECK_NONE,  1'b0, 11'd0},
		'{MODE_CLEAR,         0,        CHECK_NONE,  1'b0, 11'd0},
		'{MODE_DATA,          -32768,   CHECK_NONE,  1'b0, 11'd0},
		'{MODE_IGNORED_FIRST, -1,       CHECK_NONE,  1'b0, 11'd0},
		'{MODE_IGNORED_LAST,  16'h5555, CHECK_NONE,  1'b0, 11'd0},
		'{MODE_DATA,          -7,       CHECK_MODEL, 1'b0, 11'd0},
		'{MODE_DATA,          -7,       CHECK_MODEL, 1'b0, 11'd0},
		'{MODE_DATA,          -7,       CHECK_MODEL, 1'b0, 11'd0},
		'{MODE_DATA,          9,        CHECK_GIVEN, 1'b1, 11'd1},
		'{MODE_DATA,          9,        CHECK_MODEL, 1'b0, 11'd0},
		'{MODE_DATA,          9,        CHECK_MODEL, 1'b0, 11'd0},
		'{MODE_DATA,          9,        CHECK_MODEL, 1'b0, 11'd0},
		'{MODE_FLUSH,         0,        CHECK_GIVEN, 1'b0, 11'd1},
		'{MODE_CAL,           500,      CHECK_NONE,  1'b0, 11'd0}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt > CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_runs.size() == 0) begin
				$error("unexpected result: bit_level %0d bit_count %0d",
					out_data.bit_level, out_data.bit_count);
				mismatches++;
			end else begin
				want = awaited_runs.pop_front();
				if (out_data.bit_level !== want.bit_level) begin
					$error("bit_level: expected %0d, actual %0d",
						want.bit_level, out_data.bit_level);
					mismatches++;
				end
				if (out_data.bit_count !== want.bit_count) begin
					$error("bit_count: expected %0d, actual %0d",
						want.bit_count, out_data.bit_count);
					mismatches++;
				end
			end
		end
	end

	function automatic bit thr_ok();
		return man_en || cal_ok;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] active_thr();
		return man_en ? man_thr : cal_thr;
	endfunction

	// run length in samples to bit count, nearest with ties to even, saturating
	function automatic logic [COUNT_W-1:0] bits_for_run(logic [RUN_W-1:0] run);
		longint unsigned prod, quo, rem;
		prod = longint'(run) * BIT_RATE;
		quo = prod / ADC_RATE;
		rem = prod % ADC_RATE;
		if (2 * rem > ADC_RATE || (2 * rem == ADC_RATE && quo[0]))
			quo++;
		if (quo > COUNT_MAX)
			quo = COUNT_MAX;
		return quo[COUNT_W-1:0];
	endfunction

	task automatic slice_and_count(input in_item_t it, output bit emits,
			output out_item_t run_out);
		logic signed [SAMPLE_W-1:0] s;
		logic [COUNT_W-1:0]         cnt;
		bit                         hi;
		int                         mid;
		emits = 1'b0;
		run_out = '0;
		s = $signed(it.sample);
		case (it.mode)
			MODE_DATA: begin
				if (thr_ok()) begin
					hi = (s >= active_thr());
					if (run_len == 0) begin
						run_len = RUN_W'(1);
						run_high = hi;
					end else if (hi == run_high) begin
						if (run_len < RUN_LIMIT)
							run_len++;
					end else begin
						cnt = bits_for_run(run_len);
						if (cnt == 0)
							cnt = COUNT_W'(1);
						run_out.bit_level = !run_high ^ pol_inv;
						run_out.bit_count = cnt;
						emits = 1'b1;
						run_len = RUN_W'(1);
						run_high = hi;
					end
				end
			end
			MODE_CAL: begin
				if (!(cal_len != 0 && cal_seen >= cal_len)) begin
					if (cal_seen == 0) begin
						cal_lo = s;
						cal_hi = s;
					end else begin
						if (s < cal_lo)
							cal_lo = s;
						if (s > cal_hi)
							cal_hi = s;
					end
					if (cal_seen != {CAL_CNT_W{1'b1}})
						cal_seen++;
				end
			end
			MODE_CAL_END: begin
				if (cal_seen != 0) begin
					mid = (int'(cal_lo) + int'(cal_hi)) / 2;
					cal_thr = mid[SAMPLE_W-1:0];
					cal_ok = 1'b1;
					cal_seen = '0;
				end
			end
			MODE_FLUSH: begin
				if (thr_ok() && run_len != 0) begin
					// no forced minimum here; a zero count is dropped
					cnt = bits_for_run(run_len);
					run_out.bit_level = !run_high ^ pol_inv;
					run_out.bit_count = cnt;
					emits = (cnt != 0);
					run_len = '0;
					run_high = 1'b0;
				end
			end
			MODE_CLEAR: begin
				run_len = '0;
				run_high = 1'b0;
			end
			default: ;
		endcase
	endtask

	// offer one item, hold it until the transfer, then predict
	task automatic offer(input logic [MODE_W-1:0] mode, input logic signed [SAMPLE_W-1:0] sample,
			input bit use_model);
		in_item_t  it;
		out_item_t run_out;
		bit        emits;
		it.mode = mode;
		it.sample = sample;
		while ($urandom_range(99) < snd_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		slice_and_count(it, emits, run_out);
		if (use_model && emits)
			awaited_runs.push_back(run_out);
	endtask

	task automatic settle();
		int unsigned waited;
		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (awaited_runs.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_runs.size() != 0) begin
			$error("%0d expected results never arrived", awaited_runs.size());
			mismatches++;
			awaited_runs.delete();
		end
		// a flush with a zero count may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_INVERT:     pol_inv = val[0];
			CFG_MAN_THRESH: man_thr = val;
			CFG_MAN_ENABLE: man_en = val[0];
			CFG_CAL_LENGTH: cal_len = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(input bit inv, input logic [CFG_W-1:0] thr, input bit men,
			input logic [CFG_W-1:0] clen);
		settle();
		write_reg(CFG_INVERT, {15'd0, inv});
		write_reg(CFG_MAN_THRESH, thr);
		write_reg(CFG_MAN_ENABLE, {15'd0, men});
		write_reg(CFG_CAL_LENGTH, clen);
	endtask

	// a sample on the requested side of the active threshold (high if no lower side exists), edges now and then
	function automatic logic signed [SAMPLE_W-1:0] level_sample(bit high);
		int t, v;
		t = thr_ok() ? int'(active_thr()) : 0;
		if (!high && t == -32768)
			high = 1'b1;
		if (high) begin
			if ($urandom_range(9) == 0)
				v = $urandom_range(1) ? 32767 : t;
			else
				v = t + int'($urandom_range(0, 32767 - t));
		end else begin
			if ($urandom_range(9) == 0)
				v = $urandom_range(1) ? -32768 : t - 1;
			else
				v = -32768 + int'($urandom_range(0, t + 32767));
		end
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic random_traffic(input int unsigned target);
		int unsigned done, r, len, i;
		bit          lvl;
		done = 0;
		lvl = 1'($urandom_range(1));
		while (done < target) begin
			r = $urandom_range(99);
			if (r < 70) begin
				if ($urandom_range(9) != 0)
					lvl = !lvl;
				len = ($urandom_range(24) == 0) ? $urandom_range(13, 300) : $urandom_range(1, 12);
				for (i = 0; i < len; i++) begin
					if (thr_ok())
						done++;
					offer(MODE_DATA, level_sample(lvl), 1'b1);
				end
			end else if (r < 78) begin
				len = $urandom_range(1, 10);
				for (i = 0; i < len; i++) begin
					offer(MODE_CAL, 16'($urandom), 1'b1);
					done++;
				end
				if ($urandom_range(9) != 0) begin
					offer(MODE_CAL_END, 16'($urandom), 1'b1);
					done++;
				end
			end else if (r < 86) begin
				offer(MODE_FLUSH, 16'($urandom), 1'b1);
				done += thr_ok();
			end else if (r < 90) begin
				offer(MODE_CLEAR, 16'($urandom), 1'b1);
				done++;
			end else if (r < 94) begin
				offer(MODE_CAL_END, 16'($urandom), 1'b1);
				done++;
			end else begin
				offer(MODE_W'($urandom_range(MODE_IGNORED_FIRST, MODE_IGNORED_LAST)),
					16'($urandom), 1'b1);
			end
		end
	endtask

	initial begin
		int unsigned i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_INVERT;
		cfg_data = '0;
		hold_req = 1'b0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		mismatches = 0;
		pol_inv = 1'b0;
		man_thr = '0;
		man_en = 1'b0;
		cal_len = '0;
		run_len = '0;
		run_high = 1'b0;
		cal_thr = '0;
		cal_ok = 1'b0;
		cal_lo = '0;
		cal_hi = '0;
		cal_seen = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed, with the reset register values
		foreach (plan[r]) begin
			offer(plan[r].mode, plan[r].sample, plan[r].check == CHECK_MODEL);
			if (plan[r].check == CHECK_GIVEN)
				awaited_runs.push_back('{bit_level: plan[r].lvl, bit_count: plan[r].cnt});
		end

		// every transfer after the first ends a run of one while the receiver holds off
		set_regs(1'b0, 16'sd0, 1'b1, 16'd0);
		hold_req = 1'b1;
		for (i = 0; i < 150; i++)
			offer(MODE_DATA, i[0] ? 16'sd1000 : -16'sd1000, 1'b1);

		set_regs(1'b0, 16'sd0, 1'b0, 16'd0);
		random_traffic(PHASE_ITEMS);

		snd_idle_pct = 61;
		set_regs(1'b1, -16'sd32768, 1'b1, 16'd0);
		random_traffic(PHASE_ITEMS);

		snd_idle_pct = 0;
		rcv_stall_pct = 61;
		set_regs(1'b0, 16'sd32767, 1'b1, 16'd0);
		random_traffic(PHASE_ITEMS);

		snd_idle_pct = 22;
		rcv_stall_pct = 22;
		set_regs(1'b1, 16'($urandom), 1'b0, 16'd1);
		random_traffic(PHASE_ITEMS);

		set_regs(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)), 16'hFFFF);
		random_traffic(PHASE_ITEMS);

		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		set_regs(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)),
			16'($urandom_range(0, 20)));
		random_traffic(PHASE_ITEMS);

		settle();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
rtl/slrb_pkg.sv
rtl/slrb_scale.sv
rtl/sliced_run_length_bit_recovery.sv
tb/sliced_run_length_bit_recovery_test.sv
